// ----- hdl/prfe_pkg.sv -----
// shared types and constants for the packed rgb444 rectangle fill engine
// no dependencies; imported by the frame store and the top level

package prfe_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    localparam int COORD_W = 12;
    localparam int COLOR_W = 12;
    localparam int PAIR_W  = 2 * COLOR_W;

    // command codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_FILL    = 2'd0,
        OP_OUTLINE = 2'd1,
        OP_READ    = 2'd2,
        OP_NOP     = 2'd3
    } opcode_t;

    // frame store access strobes
    typedef struct packed {
        logic wr_hi;
        logic wr_lo;
        logic rd;
    } store_ctrl_t;

endpackage

// ----- hdl/prfe_frame_store.sv -----
// frame store of pixel pairs: even pixel in the high half, odd pixel in the low half
// per-half write strobes, registered read; depends on prfe_pkg

module prfe_frame_store #(
    parameter int WORDS = 1,
    parameter int AW    = 1
) (
    input  logic                        clk,
    input  prfe_pkg::store_ctrl_t       ctrl,
    input  logic [AW-1:0]               addr,
    input  logic [prfe_pkg::COLOR_W-1:0] wr_color,
    output logic [prfe_pkg::PAIR_W-1:0]  rd_data
);
    import prfe_pkg::*;

    logic [PAIR_W-1:0] mem [WORDS];
    logic [PAIR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_hi)
        begin
            mem[addr][PAIR_W-1:COLOR_W] <= wr_color;
        end
        if (ctrl.wr_lo)
        begin
            mem[addr][COLOR_W-1:0] <= wr_color;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/packed_rgb444_rect_fill_engine.sv -----
// top level of the rgb444 rectangle fill engine: command sequencer, clipping, scan
// depends on prfe_pkg and prfe_frame_store
//
// read: clip, setup, store read issue and wait, then the result; outside the screen clip goes to the result
// nop goes straight to the result; fill: clip and setup, then one scan step per pixel pair touched
// per clipped row, then the result; an empty fill goes from clip straight to the result
// outline: four clipped edges run back to back, each through clip, setup and the scan of its pairs
// (clip only, for an edge clipped away), then the result
// one command at a time: the scan writes one store word per cycle through a single port
// reset clears the sequencer and output valid; the frame store is not cleared

module packed_rgb444_rect_fill_engine #(
    parameter int SCREEN_WIDTH  = prfe_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = prfe_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_pos[11:0], y_pos[23:12], rect_width[35:24], rect_height[47:36],
    // fill_color[59:48], zero[63:60]
    input  logic [63:0] s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_color[11:0], zero[15:12]
    output logic [15:0] m_axis_tdata,
    // read_inside[0]
    output logic        m_axis_tuser
);
    import prfe_pkg::*;

    localparam int PAIRS = (SCREEN_WIDTH + 1) / 2;
    localparam int WORDS = PAIRS * SCREEN_HEIGHT;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int XCW   = $clog2(SCREEN_WIDTH + 1);
    localparam int YCW   = $clog2(SCREEN_HEIGHT + 1);
    localparam int SW_   = 14;

    localparam logic signed [SW_-1:0] SW_S = SW_'(SCREEN_WIDTH);
    localparam logic signed [SW_-1:0] SH_S = SW_'(SCREEN_HEIGHT);
    localparam logic signed [SW_-1:0] ONE_S = SW_'(1);
    localparam logic signed [SW_-1:0] ZERO_S = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLIP,
        ST_SETUP,
        ST_FILL,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_RESP
    } state_t;

    state_t                 state_reg;
    opcode_t                op_reg;
    logic [1:0]             seg_reg;
    logic [COORD_W-1:0]     x_reg, y_reg, w_reg, h_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic [XCW-1:0]         x0_reg, x1_reg, cx_reg;
    logic [YCW-1:0]         y0_reg, y1_reg, cy_reg;
    logic [AW-1:0]          base_reg;
    logic [COLOR_W-1:0]     res_color_reg;
    logic                   res_inside_reg;
    logic                   m_valid_reg;
    logic [COLOR_W-1:0]     out_color_reg;
    logic                   out_inside_reg;

    logic                   s_acc;
    logic signed [SW_-1:0]  xs, ys, ws, hs;
    logic signed [SW_-1:0]  rx, ry, rw, rh;
    logic signed [SW_-1:0]  x0s, x1s, y0s, y1s, xe, ye;
    logic                   seg_nonempty, rd_inside, seg_last;
    logic                   both;
    logic [XCW:0]           cx_inc;
    logic [YCW:0]           cy_inc;
    logic                   row_end, last_row;
    store_ctrl_t            store_ctrl;
    logic [AW-1:0]          store_addr;
    logic [PAIR_W-1:0]      rd_data;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // segment rectangle for the current command, widened so edge offsets cannot wrap
    always_comb
    begin
        xs = SW_'(signed'(x_reg));
        ys = SW_'(signed'(y_reg));
        ws = SW_'(signed'(w_reg));
        hs = SW_'(signed'(h_reg));
        rx = xs;
        ry = ys;
        rw = ws;
        rh = hs;
        if (op_reg == OP_OUTLINE)
        begin
            case (seg_reg)
                2'd0:
                begin
                    rw = ws + ONE_S;
                    rh = ONE_S;
                end
                2'd1:
                begin
                    ry = ys + hs;
                    rw = ws + ONE_S;
                    rh = ONE_S;
                end
                2'd2:
                begin
                    ry = ys + ONE_S;
                    rw = ONE_S;
                    rh = hs - ONE_S;
                end
                default:
                begin
                    rx = xs + ws;
                    ry = ys + ONE_S;
                    rw = ONE_S;
                    rh = hs - ONE_S;
                end
            endcase
        end
    end

    // clip to the screen: start = max(pos, 0), end = min(pos + size, screen)
    always_comb
    begin
        xe  = rx + rw;
        ye  = ry + rh;
        x0s = (rx < ZERO_S) ? ZERO_S : rx;
        y0s = (ry < ZERO_S) ? ZERO_S : ry;
        x1s = (xe > SW_S) ? SW_S : xe;
        y1s = (ye > SH_S) ? SH_S : ye;
        seg_nonempty = (x1s > x0s) && (y1s > y0s);
        rd_inside = (rx >= ZERO_S) && (rx < SW_S) && (ry >= ZERO_S) && (ry < SH_S);
        seg_last  = (op_reg != OP_OUTLINE) || (seg_reg == 2'd3);
    end

    // scan step: a whole word when an even column and its neighbor are both covered
    always_comb
    begin
        both     = !cx_reg[0] && ({1'b0, cx_reg} + (XCW+1)'(1) < {1'b0, x1_reg});
        cx_inc   = {1'b0, cx_reg} + (both ? (XCW+1)'(2) : (XCW+1)'(1));
        row_end  = cx_inc >= {1'b0, x1_reg};
        cy_inc   = {1'b0, cy_reg} + (YCW+1)'(1);
        last_row = cy_inc >= {1'b0, y1_reg};
    end

    always_comb
    begin
        store_ctrl.wr_hi = (state_reg == ST_FILL) && !cx_reg[0];
        store_ctrl.wr_lo = (state_reg == ST_FILL) && (cx_reg[0] || both);
        store_ctrl.rd    = (state_reg == ST_RD_ISSUE);
        store_addr       = base_reg + AW'(cx_reg >> 1);
    end

    prfe_frame_store #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .ctrl     (store_ctrl),
        .addr     (store_addr),
        .wr_color (color_reg),
        .rd_data  (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_NOP;
            seg_reg        <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            w_reg          <= '0;
            h_reg          <= '0;
            color_reg      <= '0;
            x0_reg         <= '0;
            x1_reg         <= '0;
            cx_reg         <= '0;
            y0_reg         <= '0;
            y1_reg         <= '0;
            cy_reg         <= '0;
            base_reg       <= '0;
            res_color_reg  <= '0;
            res_inside_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            out_color_reg  <= '0;
            out_inside_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_RESP) && (!m_valid_reg || m_axis_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        op_reg         <= opcode_t'(s_axis_tuser);
                        x_reg          <= s_axis_tdata[11:0];
                        y_reg          <= s_axis_tdata[23:12];
                        w_reg          <= s_axis_tdata[35:24];
                        h_reg          <= s_axis_tdata[47:36];
                        color_reg      <= s_axis_tdata[59:48];
                        seg_reg        <= '0;
                        res_color_reg  <= '0;
                        res_inside_reg <= 1'b0;
                        state_reg      <= (opcode_t'(s_axis_tuser) == OP_NOP) ? ST_RESP : ST_CLIP;
                    end
                end
                ST_CLIP:
                begin
                    if (op_reg == OP_READ)
                    begin
                        x0_reg         <= rx[XCW-1:0];
                        y0_reg         <= ry[YCW-1:0];
                        res_inside_reg <= rd_inside;
                        state_reg      <= rd_inside ? ST_SETUP : ST_RESP;
                    end
                    else if (seg_nonempty)
                    begin
                        x0_reg    <= x0s[XCW-1:0];
                        x1_reg    <= x1s[XCW-1:0];
                        y0_reg    <= y0s[YCW-1:0];
                        y1_reg    <= y1s[YCW-1:0];
                        state_reg <= ST_SETUP;
                    end
                    else if (seg_last)
                    begin
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        seg_reg <= seg_reg + 2'd1;
                    end
                end
                ST_SETUP:
                begin
                    base_reg  <= AW'(y0_reg * PAIRS);
                    cx_reg    <= x0_reg;
                    cy_reg    <= y0_reg;
                    state_reg <= (op_reg == OP_READ) ? ST_RD_ISSUE : ST_FILL;
                end
                ST_FILL:
                begin
                    if (!row_end)
                    begin
                        cx_reg <= cx_inc[XCW-1:0];
                    end
                    else if (!last_row)
                    begin
                        cx_reg   <= x0_reg;
                        cy_reg   <= cy_inc[YCW-1:0];
                        base_reg <= base_reg + AW'(PAIRS);
                    end
                    else if (seg_last)
                    begin
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        seg_reg   <= seg_reg + 2'd1;
                        state_reg <= ST_CLIP;
                    end
                end
                ST_RD_ISSUE:
                begin
                    state_reg <= ST_RD_WAIT;
                end
                ST_RD_WAIT:
                begin
                    res_color_reg <= cx_reg[0] ? rd_data[COLOR_W-1:0]
                                               : rd_data[PAIR_W-1:COLOR_W];
                    state_reg     <= ST_RESP;
                end
                ST_RESP:
                begin
                    // the output register frees up while the next command may already wait
                    if (!m_valid_reg || m_axis_tready)
                    begin
                        out_color_reg  <= res_color_reg;
                        out_inside_reg <= res_inside_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_color_reg};
    assign m_axis_tuser  = out_inside_reg;

    a_write_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (store_ctrl.wr_hi || store_ctrl.wr_lo) |-> (state_reg == ST_FILL))
        else $error("frame store written outside the scan");

    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (store_ctrl.wr_hi || store_ctrl.wr_lo || store_ctrl.rd) |-> (store_addr < WORDS))
        else $error("frame store address out of range");

    a_scan_column_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (cx_reg < x1_reg) && (cy_reg < y1_reg))
        else $error("scan position beyond clipped rectangle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_axis_tready)
        else $error("new command taken while one is in progress");

    a_outside_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[11:0] == 12'd0))
        else $error("nonzero color on a result that is not an inside read");

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the packed rgb444 rectangle fill engine: directed table, then random
// depends on prfe_pkg and packed_rgb444_rect_fill_engine; keeps its own copy of the frame store
// and predicts from it every result that the directed table does not give
`timescale 1ns / 1ps

module testbench;

    import prfe_pkg::*;

    localparam int SCR_W = SCREEN_WIDTH_DEF;
    localparam int SCR_H = SCREEN_HEIGHT_DEF;
    localparam int PAIRS = (SCR_W + 1) / 2;
    localparam int WORDS = PAIRS * SCR_H;
    localparam int RANDOM_CMDS = 1000;
    localparam int PLAN_ROWS = 27;

    typedef struct {
        opcode_t            op;
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [11:0] w;
        logic signed [11:0] h;
        logic [11:0]        color;
    } fill_cmd_t;

    typedef struct {
        logic [11:0] color;
        logic        on_screen;
    } pixel_answer_t;

    typedef struct {
        opcode_t op;
        int      x;
        int      y;
        int      w;
        int      h;
        int      color;
        bit      typed;
        int      want_color;
        bit      want_inside;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [23:0]   frame_words [WORDS];
    pixel_answer_t pixel_answers [$];
    plan_row_t     plan [PLAN_ROWS];
    int            errors;
    int            hot_x;
    int            hot_y;
    bit            calm;
    int            stall_left;

    packed_rgb444_rect_fill_engine u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // one pixel, only its own half of the pair word changes
    function automatic void paint_pixel(input int px, input int py, input logic [11:0] c);
        int          idx;
        logic [23:0] wv;
        if (px < 0 || px >= SCR_W || py < 0 || py >= SCR_H)
            return;
        idx = py * PAIRS + px / 2;
        wv = frame_words[idx];
        if (px[0] == 1'b0)
            wv[23:12] = c;
        else
            wv[11:0] = c;
        frame_words[idx] = wv;
    endfunction

    function automatic void paint_rect(input int rx, input int ry, input int rw, input int rh,
                                       input logic [11:0] c);
        if (rx < 0)
        begin
            rw += rx;
            rx = 0;
        end
        if (rx + rw > SCR_W)
            rw = SCR_W - rx;
        if (ry < 0)
        begin
            rh += ry;
            ry = 0;
        end
        if (ry + rh > SCR_H)
            rh = SCR_H - ry;
        if (rw <= 0 || rh <= 0)
            return;
        for (int iy = 0; iy < rh; iy++)
            for (int ix = 0; ix < rw; ix++)
                paint_pixel(rx + ix, ry + iy, c);
    endfunction

    // applies one command to the frame copy and returns the result it should produce
    function automatic pixel_answer_t paint_and_read(input fill_cmd_t c);
        pixel_answer_t a;
        int            x;
        int            y;
        int            w;
        int            h;
        logic [23:0]   wv;
        x = int'(c.x);
        y = int'(c.y);
        w = int'(c.w);
        h = int'(c.h);
        a.color = '0;
        a.on_screen = 1'b0;
        case (c.op)
            OP_FILL:
                paint_rect(x, y, w, h, c.color);
            OP_OUTLINE:
            begin
                // box is (w+1) by (h+1): top, bottom, then the two sides between them
                paint_rect(x, y, w + 1, 1, c.color);
                paint_rect(x, y + h, w + 1, 1, c.color);
                paint_rect(x, y + 1, 1, h - 1, c.color);
                paint_rect(x + w, y + 1, 1, h - 1, c.color);
            end
            OP_READ:
            begin
                if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H)
                begin
                    wv = frame_words[y * PAIRS + x / 2];
                    a.color = (x[0] == 1'b0) ? wv[23:12] : wv[11:0];
                    a.on_screen = 1'b1;
                end
            end
            default:
                ;
        endcase
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    function automatic int pick_coord(input int span);
        int                 r;
        logic signed [11:0] raw;
        r = $urandom_range(99);
        raw = 12'($urandom);
        if (r < 80)
            return int'($urandom_range(span + 15)) - 8;
        else if (r < 92)
        begin
            case ($urandom_range(3))
                0: return -1;
                1: return 0;
                2: return span - 1;
                default: return span;
            endcase
        end
        return int'(raw);
    endfunction

    function automatic int pick_size();
        int                 r;
        logic signed [11:0] raw;
        r = $urandom_range(99);
        raw = 12'($urandom);
        if (r < 80)
            return int'($urandom_range(24)) - 4;
        else if (r < 95)
            return int'($urandom_range(80)) - 40;
        return int'(raw);
    endfunction

    function automatic fill_cmd_t random_cmd();
        fill_cmd_t c;
        int        r;
        r = $urandom_range(99);
        c.op = (r < 35) ? OP_READ : (r < 65) ? OP_FILL : (r < 88) ? OP_OUTLINE : OP_NOP;
        c.w = 12'(pick_size());
        c.h = 12'(pick_size());
        c.color = 12'($urandom);
        if (c.op == OP_READ && $urandom_range(99) < 60)
        begin
            // probe around the last painted area so reads see fresh colors
            c.x = 12'(hot_x + int'($urandom_range(14)) - 2);
            c.y = 12'(hot_y + int'($urandom_range(14)) - 2);
        end
        else
        begin
            c.x = 12'(pick_coord(SCR_W));
            c.y = 12'(pick_coord(SCR_H));
        end
        if (c.op == OP_FILL || c.op == OP_OUTLINE)
        begin
            hot_x = int'(c.x);
            hot_y = int'(c.y);
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // drives one command, records its expected result once the transaction completes
    task automatic issue(input fill_cmd_t c, input bit typed, input pixel_answer_t typed_ans);
        pixel_answer_t predicted;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, c.color, c.h, c.w, c.y, c.x};
        s_axis_tuser <= c.op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = paint_and_read(c);
        pixel_answers.push_back(typed ? typed_ans : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: random backpressure with occasional long stalls; ready when calm and not stalled
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (calm)
            m_axis_tready <= 1'b1;
        else
        begin
            case ($urandom_range(19))
                0: stall_left <= $urandom_range(40, 10);
                1, 2, 3, 4, 5: m_axis_tready <= 1'b0;
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        pixel_answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pixel_answers.size() == 0)
                report_mismatch("unexpected transaction", int'(m_axis_tdata), 0);
            else
            begin
                want = pixel_answers.pop_front();
                if (m_axis_tdata[11:0] !== want.color)
                    report_mismatch("read_color", int'(m_axis_tdata[11:0]), int'(want.color));
                if (m_axis_tuser !== want.on_screen)
                    report_mismatch("read_inside", int'(m_axis_tuser), int'(want.on_screen));
            end
        end
    end

    initial
    begin
        #50_000_000;
        $display("FAIL packed_rgb444_rect_fill_engine");
        $finish;
    end

    initial
    begin
        fill_cmd_t     c;
        pixel_answer_t ans;
        errors = 0;
        hot_x = 0;
        hot_y = 0;
        calm = 1'b0;
        stall_left = 0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= OP_NOP;
        m_axis_tready <= 1'b0;
        for (int i = 0; i < WORDS; i++)
            frame_words[i] = '0;

        // the store is undefined until written, so the first row clears the whole screen
        plan = '{
            '{OP_FILL,        0,     0,   320,  240, 'h000, 1, 'h000, 0},
            '{OP_READ,        0,     0,     0,    0, 'h000, 1, 'h000, 1},
            '{OP_FILL,        0,     0,  2047, 2047, 'hFFF, 1, 'h000, 0},
            '{OP_READ,      319,   239,     0,    0, 'h000, 1, 'hFFF, 1},
            '{OP_READ,       -1,     0,     0,    0, 'h000, 1, 'h000, 0},
            '{OP_READ,      320,     0,     0,    0, 'h000, 1, 'h000, 0},
            '{OP_READ,        0,   240,     0,    0, 'h000, 1, 'h000, 0},
            '{OP_READ,    -2048, -2048,     0,    0, 'h000, 1, 'h000, 0},
            '{OP_READ,     2047,  2047,     0,    0, 'h000, 1, 'h000, 0},
            '{OP_FILL,        5,     7,     1,    1, 'h123, 1, 'h000, 0},
            '{OP_READ,        5,     7,     0,    0, 'h000, 1, 'h123, 1},
            '{OP_READ,        4,     7,     0,    0, 'h000, 1, 'hFFF, 1},
            '{OP_FILL,        4,     7,     1,    1, 'hABC, 1, 'h000, 0},
            '{OP_READ,        4,     7,     0,    0, 'h000, 1, 'hABC, 1},
            '{OP_READ,        5,     7,     0,    0, 'h000, 1, 'h123, 1},
            '{OP_FILL,       10,    10,     0,    5, 'h555, 1, 'h000, 0},
            '{OP_FILL,       10,    10,     5,   -3, 'h555, 1, 'h000, 0},
            '{OP_FILL,    -2048, -2048,  2047, 2047, 'h000, 1, 'h000, 0},
            '{OP_READ,       10,    10,     0,    0, 'h000, 1, 'hFFF, 1},
            '{OP_FILL,       -3,    -2,     5,    4, 'h0F0, 1, 'h000, 0},
            '{OP_READ,        1,     1,     0,    0, 'h000, 0, 0, 0},
            '{OP_OUTLINE,   100,    50,    10,    6, 'hF0F, 1, 'h000, 0},
            '{OP_READ,      110,    56,     0,    0, 'h000, 0, 0, 0},
            '{OP_OUTLINE,     0,     0,  2047, 2047, 'h00F, 1, 'h000, 0},
            '{OP_OUTLINE,   200,   100,    -3,   -2, 'h3C3, 1, 'h000, 0},
            '{OP_NOP,         7,     7,  2047,   -1, 'hFFF, 1, 'h000, 0},
            '{OP_READ,      319,     0, -2048, 2047, 'hFFF, 0, 0, 0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            c.op = plan[i].op;
            c.x = 12'(plan[i].x);
            c.y = 12'(plan[i].y);
            c.w = 12'(plan[i].w);
            c.h = 12'(plan[i].h);
            c.color = 12'(plan[i].color);
            ans.color = 12'(plan[i].want_color);
            ans.on_screen = plan[i].want_inside;
            issue(c, plan[i].typed, ans);
        end

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            // every fourth stretch runs with no gaps on either side
            calm = ((n / 80) % 4) == 3;
            c = random_cmd();
            issue(c, 1'b0, ans);
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pixel_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("PASS packed_rgb444_rect_fill_engine");
        else
            $display("FAIL packed_rgb444_rect_fill_engine");
        $finish;
    end

endmodule
